// ===== src/cc20_pkg.sv =====
package cc20_pkg;

    localparam int CC_NUM_WORDS  = 16;
    localparam int CC_WORD_W     = 32;
    localparam int CC_LANES      = 4;
    localparam int CC_ROUNDS     = 20;
    localparam int CC_ROUND_W    = 5;
    localparam int CC_POS_W      = 6;
    localparam int CC_CFG_IDX_W  = 3;
    localparam int CC_CFG_DATA_W = 64;

    localparam logic [CC_ROUND_W-1:0] CC_LAST_ROUND = CC_ROUND_W'(CC_ROUNDS - 1);

    // The "expand 32-byte k" words that open the state.
    localparam logic [CC_WORD_W-1:0] CC_SIGMA [CC_LANES] = '{
        32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
    };

    // Configuration register indexes.
    localparam logic [CC_CFG_IDX_W-1:0] CFG_KEY_PART_0      = 3'd0;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_KEY_PART_1      = 3'd1;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_KEY_PART_2      = 3'd2;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_KEY_PART_3      = 3'd3;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_NONCE_LOW       = 3'd4;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_NONCE_HIGH      = 3'd5;
    localparam logic [CC_CFG_IDX_W-1:0] CFG_INITIAL_COUNTER = 3'd6;

    // Quarter-round phases: each is one add, one xor and one rotate per lane.
    localparam logic [1:0] STEP_AB_D16 = 2'd0;
    localparam logic [1:0] STEP_CD_B12 = 2'd1;
    localparam logic [1:0] STEP_AB_D8  = 2'd2;
    localparam logic [1:0] STEP_CD_B7  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       direct;
        logic       step;
        logic [1:0] step_sel;
        logic       diag;
        logic       finalize;
        logic       emit;
    } cc_cmd_t;

    typedef struct packed {
        logic pos_zero;
    } cc_status_t;

endpackage

// ===== src/cc20_if.sv =====
interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last_out;

    modport source (output valid, output cipher_byte, output last_out, input ready);
    modport sink (input valid, input cipher_byte, input last_out, output ready);
endinterface

// ===== src/cc20_ctrl.sv =====
module cc20_ctrl
    import cc20_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_ready,
    input  cc_status_t status,
    output logic       in_ready,
    output logic       out_valid,
    output cc_cmd_t    cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINAL, ST_EMIT} state_t;

    state_t                state_reg;
    logic [CC_ROUND_W-1:0] rnd_reg;
    logic [1:0]            stp_reg;
    logic                  out_valid_reg;
    logic                  slot_free;
    logic                  accept;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load     = accept && status.pos_zero;
        cmd.direct   = accept && !status.pos_zero;
        cmd.step     = (state_reg == ST_ROUND);
        cmd.step_sel = stp_reg;
        cmd.diag     = rnd_reg[0];
        cmd.finalize = (state_reg == ST_FINAL);
        cmd.emit     = (state_reg == ST_EMIT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            stp_reg       <= STEP_AB_D16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.direct || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= ST_ROUND;
                        rnd_reg   <= '0;
                        stp_reg   <= STEP_AB_D16;
                    end
                end
                ST_ROUND:
                begin
                    stp_reg <= stp_reg + 2'd1;
                    if (stp_reg == STEP_CD_B7)
                    begin
                        if (rnd_reg == CC_LAST_ROUND)
                        begin
                            state_reg <= ST_FINAL;
                        end
                        else
                        begin
                            rnd_reg <= rnd_reg + 1'b1;
                        end
                    end
                end
                ST_FINAL:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/cc20_datapath.sv =====
module cc20_datapath
    import cc20_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [CC_CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_message,
    input  cc_cmd_t                  cmd,
    output cc_status_t               status,
    output logic [7:0]               cipher_byte,
    output logic                     last_out
);

    logic [CC_CFG_DATA_W-1:0] key_reg [CC_LANES];
    logic [CC_CFG_DATA_W-1:0] nonce_low_reg;
    logic [CC_WORD_W-1:0]     nonce_high_reg;
    logic [CC_WORD_W-1:0]     init_ctr_reg;

    logic [CC_WORD_W-1:0] w_reg  [CC_NUM_WORDS];
    logic [CC_WORD_W-1:0] w_next [CC_NUM_WORDS];
    logic [CC_WORD_W-1:0] init_w [CC_NUM_WORDS];
    logic [CC_WORD_W-1:0] ctr_reg;
    logic [CC_WORD_W-1:0] ctr_sum;
    logic [CC_WORD_W-1:0] offset_reg;
    logic [CC_POS_W-1:0]  pos_reg;
    logic [7:0]           data_reg;
    logic                 hold_last_reg;
    logic [7:0]           cipher_reg;
    logic                 last_out_reg;
    logic [CC_WORD_W-1:0] ks_word;
    logic [7:0]           ks_byte;
    logic                 ab_phase;

    logic [CC_WORD_W-1:0] lane_a [CC_LANES];
    logic [CC_WORD_W-1:0] lane_b [CC_LANES];
    logic [CC_WORD_W-1:0] lane_c [CC_LANES];
    logic [CC_WORD_W-1:0] lane_d [CC_LANES];

    function automatic logic [CC_WORD_W-1:0] rotl32(input logic [CC_WORD_W-1:0] v,
                                                    input int unsigned n);
        return (v << n) | (v >> (CC_WORD_W - n));
    endfunction

    assign ctr_sum  = init_ctr_reg + offset_reg;
    assign ab_phase = (cmd.step_sel == STEP_AB_D16) || (cmd.step_sel == STEP_AB_D8);

    // Input state: constants, key, counter and nonce, little-endian words.
    always_comb
    begin
        for (int i = 0; i < CC_LANES; i++)
        begin
            init_w[i] = CC_SIGMA[i];
        end
        for (int k = 0; k < CC_LANES; k++)
        begin
            init_w[4 + 2 * k] = key_reg[k][CC_WORD_W-1:0];
            init_w[5 + 2 * k] = key_reg[k][CC_CFG_DATA_W-1:CC_WORD_W];
        end
        init_w[12] = cmd.load ? ctr_sum : ctr_reg;
        init_w[13] = nonce_low_reg[CC_WORD_W-1:0];
        init_w[14] = nonce_low_reg[CC_CFG_DATA_W-1:CC_WORD_W];
        init_w[15] = nonce_high_reg;
    end

    // Four quarter rounds run side by side, one phase of each per cycle.
    for (genvar l = 0; l < CC_LANES; l++)
    begin : g_lane
        localparam int IB_C = 4 + l;
        localparam int IB_D = 4 + ((l + 1) & 3);
        localparam int IC_C = 8 + l;
        localparam int IC_D = 8 + ((l + 2) & 3);
        localparam int ID_C = 12 + l;
        localparam int ID_D = 12 + ((l + 3) & 3);

        logic [CC_WORD_W-1:0] a, b, c, d, sab, scd;

        assign a   = w_reg[l];
        assign b   = cmd.diag ? w_reg[IB_D] : w_reg[IB_C];
        assign c   = cmd.diag ? w_reg[IC_D] : w_reg[IC_C];
        assign d   = cmd.diag ? w_reg[ID_D] : w_reg[ID_C];
        assign sab = a + b;
        assign scd = c + d;

        assign lane_a[l] = sab;
        assign lane_c[l] = scd;
        assign lane_d[l] = (cmd.step_sel == STEP_AB_D8) ? rotl32(d ^ sab, 8)
                                                        : rotl32(d ^ sab, 16);
        assign lane_b[l] = (cmd.step_sel == STEP_CD_B7) ? rotl32(b ^ scd, 7)
                                                        : rotl32(b ^ scd, 12);
    end

    always_comb
    begin
        w_next = w_reg;
        priority if (cmd.load)
        begin
            w_next = init_w;
        end
        else if (cmd.step)
        begin
            for (int l = 0; l < CC_LANES; l++)
            begin
                if (ab_phase)
                begin
                    w_next[l] = lane_a[l];
                    if (cmd.diag)
                        w_next[12 + ((l + 3) & 3)] = lane_d[l];
                    else
                        w_next[12 + l] = lane_d[l];
                end
                else
                begin
                    if (cmd.diag)
                    begin
                        w_next[8 + ((l + 2) & 3)] = lane_c[l];
                        w_next[4 + ((l + 1) & 3)] = lane_b[l];
                    end
                    else
                    begin
                        w_next[8 + l] = lane_c[l];
                        w_next[4 + l] = lane_b[l];
                    end
                end
            end
        end
        else if (cmd.finalize)
        begin
            for (int i = 0; i < CC_NUM_WORDS; i++)
            begin
                w_next[i] = w_reg[i] + init_w[i];
            end
        end
    end

    // After the final add the working words hold the keystream block.
    assign ks_word = w_reg[pos_reg[CC_POS_W-1:2]];
    assign ks_byte = 8'(ks_word >> {pos_reg[1:0], 3'b000});

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (cmd.load)
        begin
            ctr_reg       <= ctr_sum;
            data_reg      <= data_byte;
            hold_last_reg <= end_of_message;
        end
        if (cmd.direct)
        begin
            cipher_reg   <= data_byte ^ ks_byte;
            last_out_reg <= end_of_message;
        end
        else if (cmd.emit)
        begin
            cipher_reg   <= data_reg ^ w_reg[0][7:0];
            last_out_reg <= hold_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CC_LANES; k++)
            begin
                key_reg[k] <= '0;
            end
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
            pos_reg        <= '0;
            offset_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_PART_0:      key_reg[0]     <= cfg_data;
                    CFG_KEY_PART_1:      key_reg[1]     <= cfg_data;
                    CFG_KEY_PART_2:      key_reg[2]     <= cfg_data;
                    CFG_KEY_PART_3:      key_reg[3]     <= cfg_data;
                    CFG_NONCE_LOW:       nonce_low_reg  <= cfg_data;
                    CFG_NONCE_HIGH:      nonce_high_reg <= cfg_data[CC_WORD_W-1:0];
                    CFG_INITIAL_COUNTER: init_ctr_reg   <= cfg_data[CC_WORD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load || cmd.direct)
            begin
                if (end_of_message)
                begin
                    pos_reg    <= '0;
                    offset_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                    if (&pos_reg)
                    begin
                        offset_reg <= offset_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign status.pos_zero = (pos_reg == '0);
    assign cipher_byte     = cipher_reg;
    assign last_out        = last_out_reg;

endmodule

// ===== src/chacha20_stream_cipher.sv =====
// A byte inside a block comes out in the cycle after it is taken; the first byte of
// each 64-byte block comes out after the load, 80 round phases, one final add and one
// output write, and that write waits until the output register is free.
// Within a block one byte is taken per cycle while the output register is free; no
// byte is taken while a keystream block is being built.
// Reset (rst_n, asynchronous, active low) clears the control state, configuration, position, offset.
module chacha20_stream_cipher
    import cc20_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CC_CFG_IDX_W-1:0]  cfg_index,
    input  logic [CC_CFG_DATA_W-1:0] cfg_data,
    cc20_in_if.sink                  byte_stream,
    cc20_out_if.source               cipher_stream
);

    // The controller sequences the work on each request: a byte in the middle of a
    // block is combined with the stored keystream at once, while the first byte of
    // a block starts a keystream build. The build runs the four quarter rounds of a
    // column or diagonal round side by side, one add-xor-rotate phase per cycle, with four
    // phases to a round and twenty rounds in all. A final step adds the input state back
    // in, and the byte is then combined and written out.

    cc_cmd_t    cmd;
    cc_status_t status;
    logic       in_ready;
    logic       out_valid;

    cc20_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (byte_stream.valid),
        .out_ready (cipher_stream.ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the sixteen working words that become
    // the keystream block, the byte position, the block offset and the output register.
    cc20_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_byte      (byte_stream.data_byte),
        .end_of_message (byte_stream.end_of_message),
        .cmd            (cmd),
        .status         (status),
        .cipher_byte    (cipher_stream.cipher_byte),
        .last_out       (cipher_stream.last_out)
    );

    // A new request is taken while the previous result is still leaving the output
    // register, provided the keystream is not being built.
    assign byte_stream.ready   = in_ready;
    assign cipher_stream.valid = out_valid;

    // No request is taken while the rounds or the final add are running.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.finalize) |-> !byte_stream.ready)
        else $error("request accepted during keystream build");

    // A block build always starts with the first phase of a column round.
    a_load_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.step && !cmd.diag && cmd.step_sel == STEP_AB_D16))
        else $error("keystream build did not start at the first column phase");

    // The controller never issues two datapath commands at once.
    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.direct, cmd.step, cmd.finalize, cmd.emit}))
        else $error("conflicting datapath commands");

    // A result appears only after a direct combine or the write of a built block.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cipher_stream.valid) |-> $past(cmd.direct || cmd.emit))
        else $error("result valid without a combine");

endmodule
